// ===== rtl/core/gheat_pkg.sv =====
// gheat_pkg: shared types, constants and helpers of the grid heat exchange stencil
// no dependencies; the other files of the block, except gheat_fifo, refer to it by scoped names
package gheat_pkg;

   // field widths fixed by the cell format
   localparam int TEMP_W  = 12;
   localparam int PROP_W  = 8;
   localparam int DELTA_W = 8;
   localparam int POS_W   = 10;
   localparam int CFG_W   = 11;
   localparam int CSR_AW  = 3;
   localparam int CSR_DW  = 32;
   localparam int WIDE_W  = 14;

   // exchange arithmetic
   localparam int E_W        = 5;    // energy and share width
   localparam int DVD_W      = 13;   // energy times capacity
   localparam int DVS_W      = 9;    // capacity sum
   localparam int GAP_W      = 12;
   localparam int GAP_MIN    = 4;
   localparam int ENERGY_SH  = 8;    // divide by 256
   localparam int ENERGY_MAX = 18;
   localparam int TEMP_LOW   = -50;
   localparam int TEMP_HIGH  = 2000;
   localparam int SIZE_MIN   = 3;

   localparam logic signed [WIDE_W-1:0] WIDE_LOW  = WIDE_W'(TEMP_LOW);
   localparam logic signed [WIDE_W-1:0] WIDE_HIGH = WIDE_W'(TEMP_HIGH);

   // register indexes
   localparam logic [0:0] REG_GRID_WIDTH  = 1'b0;
   localparam logic [0:0] REG_GRID_HEIGHT = 1'b1;

   // one stored cell: inputs plus accumulated exchange
   typedef struct packed {
      logic signed [TEMP_W-1:0]  temp;
      logic                      empty;
      logic [PROP_W-1:0]         cond;
      logic [PROP_W-1:0]         cap;
      logic [PROP_W-1:0]         relax;
      logic signed [TEMP_W-1:0]  eq;
      logic signed [TEMP_W-1:0]  imp;
      logic signed [DELTA_W-1:0] delta;
   } cell_type;

   // classification of one transaction by its grid position
   typedef struct packed {
      logic do_v;    // exchange with the cell above
      logic do_h;    // exchange with the cell to the left
      logic emit;    // the cell above is finished and emitted
      logic last;    // last emitted cell of the frame
   } flags_type;

   // clamp a wide signed temperature to the legal range
   function automatic logic signed [TEMP_W-1:0] clamp_temp(input logic signed [WIDE_W-1:0] v);
      logic signed [WIDE_W-1:0] r;
      r = v;
      if (v < WIDE_LOW) begin
         r = WIDE_LOW;
      end else if (v > WIDE_HIGH) begin
         r = WIDE_HIGH;
      end
      return r[TEMP_W-1:0];
   endfunction

endpackage

// ===== rtl/core/gheat_req_if.sv =====
// gheat_req_if: input cell channel with valid/ready handshake
// depends on gheat_pkg for field widths
interface gheat_req_if;
   logic                                     valid;
   logic                                     ready;
   logic signed [gheat_pkg::TEMP_W-1:0]      cell_temp;
   logic                                     cell_empty;
   logic [gheat_pkg::PROP_W-1:0]             conductivity;
   logic [gheat_pkg::PROP_W-1:0]             specific_heat;
   logic [gheat_pkg::PROP_W-1:0]             relax_step;
   logic signed [gheat_pkg::TEMP_W-1:0]      equilibrium_temp;
   logic signed [gheat_pkg::TEMP_W-1:0]      impulse_in;

   modport source (output valid, cell_temp, cell_empty, conductivity, specific_heat,
                   relax_step, equilibrium_temp, impulse_in, input ready);
   modport sink (input valid, cell_temp, cell_empty, conductivity, specific_heat,
                 relax_step, equilibrium_temp, impulse_in, output ready);
endinterface

// ===== rtl/core/gheat_rsp_if.sv =====
// gheat_rsp_if: result channel with valid/ready handshake
// depends on gheat_pkg for field widths
interface gheat_rsp_if;
   logic                                 valid;
   logic                                 ready;
   logic signed [gheat_pkg::TEMP_W-1:0]  new_temp;
   logic [gheat_pkg::POS_W-1:0]          cell_col;
   logic [gheat_pkg::POS_W-1:0]          cell_row;
   logic                                 frame_last;

   modport source (output valid, new_temp, cell_col, cell_row, frame_last, input ready);
   modport sink (input valid, new_temp, cell_col, cell_row, frame_last, output ready);
endinterface

// ===== rtl/core/gheat_front.sv =====
// gheat_front: accepts cell transactions, tracks raster position, classifies them
// depends on gheat_pkg and gheat_req_if
module gheat_front #(
   parameter int MAX_WIDTH  = 1024,
   parameter int MAX_HEIGHT = 1024,
   parameter int WSW        = 11,
   parameter int HSW        = 11,
   localparam int XW        = $clog2(MAX_WIDTH)
) (
   input  logic                              clock,
   input  logic                              reset,
   gheat_req_if.sink                         req_chan,
   input  logic [WSW-1:0]                    width_eff,
   input  logic [HSW-1:0]                    height_eff,
   input  logic                              fifo_full,
   output logic                              push,
   output gheat_pkg::cell_type               push_cell,
   output gheat_pkg::flags_type              push_flags,
   output logic [XW-1:0]                     push_x,
   output logic [gheat_pkg::POS_W-1:0]       push_col,
   output logic [gheat_pkg::POS_W-1:0]       push_row
);
   localparam int YW = $clog2(MAX_HEIGHT);

   logic [XW-1:0]  col_ff, col_in;
   logic [YW-1:0]  row_ff, row_in;
   logic [WSW-1:0] x_pos, x_next;
   logic [HSW-1:0] y_step, y_pos, y_next;
   logic           x_in, y_in;

   // current position, wrapped against the present size
   always_comb begin
      x_pos  = WSW'(col_ff);
      y_step = HSW'(row_ff);
      if (x_pos >= width_eff) begin
         x_pos  = '0;
         y_step = y_step + HSW'(1);
      end
      y_pos = (y_step >= height_eff) ? '0 : y_step;
   end

   // interior tests and transaction classification
   always_comb begin
      x_in = (x_pos >= WSW'(1)) && (x_pos <= width_eff - WSW'(2));
      y_in = (y_pos >= HSW'(1)) && (y_pos <= height_eff - HSW'(2));
      push_flags.do_v = x_in && (y_pos >= HSW'(2)) && (y_pos <= height_eff - HSW'(2));
      push_flags.do_h = y_in && (x_pos >= WSW'(2)) && (x_pos <= width_eff - WSW'(2));
      push_flags.emit = x_in && (y_pos >= HSW'(2));
      push_flags.last = (x_pos == width_eff - WSW'(2)) && (y_pos == height_eff - HSW'(1));
   end

   // next position
   always_comb begin
      x_next = x_pos + WSW'(1);
      y_next = y_pos;
      if (x_next >= width_eff) begin
         x_next = '0;
         y_next = y_pos + HSW'(1);
         if (y_next >= height_eff) begin
            y_next = '0;
         end
      end
      col_in = x_next[XW-1:0];
      row_in = y_next[YW-1:0];
   end

   // handshake and payload toward the queue
   assign req_chan.ready = !fifo_full;
   assign push           = req_chan.valid && !fifo_full;
   assign push_x         = x_pos[XW-1:0];
   assign push_col       = gheat_pkg::POS_W'(x_pos);
   assign push_row       = gheat_pkg::POS_W'(y_pos - HSW'(1));

   always_comb begin
      push_cell.temp  = req_chan.cell_temp;
      push_cell.empty = req_chan.cell_empty;
      push_cell.cond  = req_chan.conductivity;
      push_cell.cap   = req_chan.specific_heat;
      push_cell.relax = req_chan.relax_step;
      push_cell.eq    = req_chan.equilibrium_temp;
      push_cell.imp   = req_chan.impulse_in;
      push_cell.delta = '0;
   end

   // raster counters
   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
         row_ff <= '0;
      end else if (push) begin
         col_ff <= col_in;
         row_ff <= row_in;
      end
   end
endmodule

// ===== rtl/core/gheat_fifo.sv =====
// gheat_fifo: two-entry show-ahead queue between front and back
// no package dependencies
module gheat_fifo #(
   parameter int DW = 8
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          push,
   input  logic [DW-1:0] din,
   output logic          full,
   input  logic          pop,
   output logic [DW-1:0] dout,
   output logic          empty
);
   logic [DW-1:0] slot_ff [2];
   logic [1:0]    count_ff;
   logic          wr_ff, rd_ff;

   assign full  = (count_ff == 2'd2);
   assign empty = (count_ff == 2'd0);
   assign dout  = slot_ff[rd_ff];

   // storage
   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ff] <= din;
      end
   end

   // pointers and fill level
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         wr_ff    <= 1'b0;
         rd_ff    <= 1'b0;
      end else begin
         if (push) begin
            wr_ff <= !wr_ff;
         end
         if (pop) begin
            rd_ff <= !rd_ff;
         end
         count_ff <= count_ff + {1'b0, push} - {1'b0, pop};
      end
   end
endmodule

// ===== rtl/core/gheat_div.sv =====
// gheat_div: restoring divider, one quotient bit per cycle, for heat shares
// depends on gheat_pkg; quotient is known to stay below 2**E_W
module gheat_div (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             start,
   input  logic [gheat_pkg::DVD_W-1:0]      dividend,
   input  logic [gheat_pkg::DVS_W-1:0]      divisor,
   output logic                             busy,
   output logic [gheat_pkg::E_W-1:0]        quot,
   output logic                             rem_nz
);
   localparam int TW = gheat_pkg::DVD_W + 1;
   localparam int CW = $clog2(gheat_pkg::E_W);

   logic [gheat_pkg::DVD_W-1:0] rem_ff;
   logic [gheat_pkg::DVS_W-1:0] dvs_ff;
   logic [gheat_pkg::E_W-1:0]   quot_ff;
   logic [CW-1:0]               cnt_ff;
   logic                        busy_ff;
   logic [TW-1:0]               trial;
   logic                        fits;

   // compare against the divisor shifted to the current quotient bit
   always_comb begin
      trial = TW'(dvs_ff) << cnt_ff;
      fits  = TW'(rem_ff) >= trial;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else if (start) begin
         busy_ff <= 1'b1;
         rem_ff  <= dividend;
         dvs_ff  <= divisor;
         quot_ff <= '0;
         cnt_ff  <= CW'(gheat_pkg::E_W - 1);
      end else if (busy_ff) begin
         if (fits) begin
            rem_ff <= rem_ff - trial[gheat_pkg::DVD_W-1:0];
         end
         quot_ff <= {quot_ff[gheat_pkg::E_W-2:0], fits};
         cnt_ff  <= cnt_ff - CW'(1);
         if (cnt_ff == '0) begin
            busy_ff <= 1'b0;
         end
      end
   end

   assign busy   = busy_ff;
   assign quot   = quot_ff;
   assign rem_nz = (rem_ff != '0);
endmodule

// ===== rtl/core/gheat_back.sv =====
// gheat_back: line store, pair exchange, relaxation and result register
// depends on gheat_pkg, gheat_rsp_if and gheat_div
module gheat_back #(
   parameter int MAX_WIDTH = 1024,
   localparam int XW       = $clog2(MAX_WIDTH)
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          empty,
   input  gheat_pkg::cell_type           head_cell,
   input  gheat_pkg::flags_type          head_flags,
   input  logic [XW-1:0]                 head_x,
   input  logic [gheat_pkg::POS_W-1:0]   head_col,
   input  logic [gheat_pkg::POS_W-1:0]   head_row,
   output logic                          pop,
   gheat_rsp_if.source                   rsp_chan
);
   localparam int TW = gheat_pkg::TEMP_W;
   localparam int WW = gheat_pkg::WIDE_W;
   localparam int DW = gheat_pkg::DELTA_W;
   localparam int EW = gheat_pkg::E_W;
   localparam int PW = gheat_pkg::PROP_W;

   typedef enum logic [2:0] {S_IDLE, S_SETUP, S_LOAD, S_DIV, S_APPLY, S_SUM, S_FIN} state_type;

   state_type                     state_ff;
   gheat_pkg::cell_type           up_ff, cur_ff, left_ff;
   gheat_pkg::flags_type          flags_ff;
   logic [XW-1:0]                 x_ff;
   logic [gheat_pkg::POS_W-1:0]   col_ff, row_ff;
   logic signed [DW-1:0]          up_delta_ff;
   logic signed [TW-1:0]          t_ff;
   gheat_pkg::cell_type           mem [MAX_WIDTH];

   // pair registers: vertical (up, cur) and horizontal (left, cur)
   logic          act_v_ff, hot_v_ff, act_h_ff, hot_h_ff;
   logic [EW-1:0] e_v_ff, e_h_ff;
   logic [PW-1:0] ca_v_ff, cb_v_ff, ca_h_ff, cb_h_ff;

   // result register
   logic                          rsp_valid_ff;
   logic signed [TW-1:0]          rsp_temp_ff;
   logic [gheat_pkg::POS_W-1:0]   rsp_col_ff, rsp_row_ff;
   logic                          rsp_last_ff;

   // divider hookup
   logic                     div_start;
   logic                     busy_v, busy_h, rnz_v, rnz_h;
   logic [EW-1:0]            q_v, q_h;
   logic [gheat_pkg::DVD_W-1:0] dvd_v, dvd_h;
   logic [gheat_pkg::DVS_W-1:0] dvs_v, dvs_h;

   // pair setup terms
   logic signed [TW:0]   dv, dh;
   logic [TW:0]          adv, adh;
   logic [PW-1:0]        cmin_v, cmin_h;
   logic                 act_v, act_h;
   logic [EW-1:0]        e_v, e_h;

   // apply terms
   logic [EW-1:0]        da_v, db_v, da_h, db_h, rest_v, rest_h;
   logic signed [DW-1:0] up_delta_new, cur_delta_new, left_delta_new;
   gheat_pkg::cell_type  left_new;

   // finish terms
   logic signed [WW-1:0] t_sum, ts, tg, rs, t_rel;
   logic                 hotter, colder;
   logic                 out_free;

   // memory port
   logic                 wr_en;
   logic [XW-1:0]        wr_addr;
   gheat_pkg::cell_type  wr_data;

   function automatic logic [EW-1:0] energy(input logic [TW:0] gap, input logic [PW-1:0] cond);
      logic [TW+PW:0] prod;
      logic [TW:0]    raw;
      logic [EW-1:0]  e;
      prod = (TW+PW+1)'(gap) * (TW+PW+1)'(cond);
      raw  = prod[TW+PW:gheat_pkg::ENERGY_SH];
      if (raw == '0) begin
         e = EW'(1);
      end else if (raw > (TW+1)'(gheat_pkg::ENERGY_MAX)) begin
         e = EW'(gheat_pkg::ENERGY_MAX);
      end else begin
         e = raw[EW-1:0];
      end
      return e;
   endfunction

   function automatic logic [PW-1:0] cap_floor(input logic [PW-1:0] c);
      return (c == '0) ? PW'(1) : c;
   endfunction

   // pair classification and energy for both pairs
   always_comb begin
      dv     = $signed({up_ff.temp[TW-1], up_ff.temp}) - $signed({cur_ff.temp[TW-1], cur_ff.temp});
      dh     = $signed({left_ff.temp[TW-1], left_ff.temp})
               - $signed({cur_ff.temp[TW-1], cur_ff.temp});
      adv    = (dv < 0) ? (TW+1)'(-dv) : (TW+1)'(dv);
      adh    = (dh < 0) ? (TW+1)'(-dh) : (TW+1)'(dh);
      cmin_v = (up_ff.cond < cur_ff.cond) ? up_ff.cond : cur_ff.cond;
      cmin_h = (left_ff.cond < cur_ff.cond) ? left_ff.cond : cur_ff.cond;
      act_v  = flags_ff.do_v && !up_ff.empty && !cur_ff.empty && (cmin_v != '0)
               && (adv >= (TW+1)'(gheat_pkg::GAP_MIN));
      act_h  = flags_ff.do_h && !left_ff.empty && !cur_ff.empty && (cmin_h != '0)
               && (adh >= (TW+1)'(gheat_pkg::GAP_MIN));
      e_v    = energy(adv, cmin_v);
      e_h    = energy(adh, cmin_h);
   end

   // division operands: energy times the other capacity over the capacity sum
   always_comb begin
      div_start = (state_ff == S_LOAD);
      dvd_v     = gheat_pkg::DVD_W'(e_v_ff) * gheat_pkg::DVD_W'(cb_v_ff);
      dvd_h     = gheat_pkg::DVD_W'(e_h_ff) * gheat_pkg::DVD_W'(cb_h_ff);
      dvs_v     = gheat_pkg::DVS_W'(ca_v_ff) + gheat_pkg::DVS_W'(cb_v_ff);
      dvs_h     = gheat_pkg::DVS_W'(ca_h_ff) + gheat_pkg::DVS_W'(cb_h_ff);
   end

   gheat_div u_div_v (
      .clock(clock), .reset(reset), .start(div_start), .dividend(dvd_v), .divisor(dvs_v),
      .busy(busy_v), .quot(q_v), .rem_nz(rnz_v)
   );

   gheat_div u_div_h (
      .clock(clock), .reset(reset), .start(div_start), .dividend(dvd_h), .divisor(dvs_h),
      .busy(busy_h), .quot(q_h), .rem_nz(rnz_h)
   );

   // shares: the second one follows from quotient and remainder of the first
   always_comb begin
      rest_v = e_v_ff - q_v - EW'(rnz_v);
      rest_h = e_h_ff - q_h - EW'(rnz_h);
      da_v   = (q_v == '0) ? EW'(1) : q_v;
      db_v   = (rest_v == '0) ? EW'(1) : rest_v;
      da_h   = (q_h == '0) ? EW'(1) : q_h;
      db_h   = (rest_h == '0) ? EW'(1) : rest_h;

      up_delta_new   = up_delta_ff;
      cur_delta_new  = cur_ff.delta;
      left_delta_new = left_ff.delta;
      if (act_v_ff) begin
         if (hot_v_ff) begin
            up_delta_new  = up_delta_new - $signed(DW'(da_v));
            cur_delta_new = cur_delta_new + $signed(DW'(db_v));
         end else begin
            up_delta_new  = up_delta_new + $signed(DW'(da_v));
            cur_delta_new = cur_delta_new - $signed(DW'(db_v));
         end
      end
      if (act_h_ff) begin
         if (hot_h_ff) begin
            left_delta_new = left_delta_new - $signed(DW'(da_h));
            cur_delta_new  = cur_delta_new + $signed(DW'(db_h));
         end else begin
            left_delta_new = left_delta_new + $signed(DW'(da_h));
            cur_delta_new  = cur_delta_new - $signed(DW'(db_h));
         end
      end
      left_new       = left_ff;
      left_new.delta = left_delta_new;
   end

   // summed temperature and relaxation toward equilibrium
   always_comb begin
      t_sum  = WW'(up_ff.temp) + WW'(up_delta_ff) + WW'(up_ff.imp);
      ts     = WW'(t_ff);
      tg     = WW'(up_ff.eq);
      rs     = $signed(WW'(up_ff.relax));
      hotter = (up_delta_ff > 0) && (ts > tg);
      colder = (up_delta_ff < 0) && (ts < tg);
      t_rel  = ts;
      if ((up_ff.relax != '0) && !hotter && !colder) begin
         if (ts > tg) begin
            t_rel = (ts - rs < tg) ? tg : ts - rs;
         end else if (ts < tg) begin
            t_rel = (ts + rs > tg) ? tg : ts + rs;
         end
      end
      out_free = !flags_ff.emit || !rsp_valid_ff || rsp_chan.ready;
   end

   // line store: one write and one registered read per cycle
   always_comb begin
      wr_en   = 1'b0;
      wr_addr = x_ff;
      wr_data = cur_ff;
      if (state_ff == S_APPLY) begin
         wr_en   = flags_ff.do_h;
         wr_addr = x_ff - XW'(1);
         wr_data = left_new;
      end else if (state_ff == S_SUM) begin
         wr_en = 1'b1;
      end
   end

   assign pop = (state_ff == S_IDLE) && !empty;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (pop) begin
         up_ff <= mem[head_x];
      end
   end

   // sequencer and result register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         // clear on handoff unless a new result is loaded in the same cycle
         if (rsp_valid_ff && rsp_chan.ready
             && !((state_ff == S_FIN) && out_free && flags_ff.emit)) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            S_IDLE: begin
               if (!empty) begin
                  cur_ff   <= head_cell;
                  flags_ff <= head_flags;
                  x_ff     <= head_x;
                  col_ff   <= head_col;
                  row_ff   <= head_row;
                  state_ff <= S_SETUP;
               end
            end
            S_SETUP: begin
               act_v_ff    <= act_v;
               hot_v_ff    <= (dv > 0);
               e_v_ff      <= e_v;
               ca_v_ff     <= cap_floor(up_ff.cap);
               cb_v_ff     <= cap_floor(cur_ff.cap);
               act_h_ff    <= act_h;
               hot_h_ff    <= (dh > 0);
               e_h_ff      <= e_h;
               ca_h_ff     <= cap_floor(left_ff.cap);
               cb_h_ff     <= cap_floor(cur_ff.cap);
               up_delta_ff <= up_ff.delta;
               state_ff    <= S_LOAD;
            end
            S_LOAD: begin
               state_ff <= S_DIV;
            end
            S_DIV: begin
               if (!busy_v && !busy_h) begin
                  state_ff <= S_APPLY;
               end
            end
            S_APPLY: begin
               up_delta_ff   <= up_delta_new;
               cur_ff.delta  <= cur_delta_new;
               left_ff.delta <= left_delta_new;
               state_ff      <= S_SUM;
            end
            S_SUM: begin
               t_ff     <= gheat_pkg::clamp_temp(t_sum);
               left_ff  <= cur_ff;
               state_ff <= S_FIN;
            end
            S_FIN: begin
               if (out_free) begin
                  if (flags_ff.emit) begin
                     rsp_valid_ff <= 1'b1;
                     rsp_temp_ff  <= gheat_pkg::clamp_temp(t_rel);
                     rsp_col_ff   <= col_ff;
                     rsp_row_ff   <= row_ff;
                     rsp_last_ff  <= flags_ff.last;
                  end
                  state_ff <= S_IDLE;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   assign rsp_chan.valid      = rsp_valid_ff;
   assign rsp_chan.new_temp   = rsp_temp_ff;
   assign rsp_chan.cell_col   = rsp_col_ff;
   assign rsp_chan.cell_row   = rsp_row_ff;
   assign rsp_chan.frame_last = rsp_last_ff;

   // dividers are quiet whenever no transaction is being worked on
   a_div_idle: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_IDLE) |-> (!busy_v && !busy_h))
      else $error("divider busy while back end idle");

   // an active vertical pair carries an energy between one and the cap
   a_energy_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_LOAD && act_v_ff) |-> (e_v_ff >= EW'(1) && e_v_ff <= EW'(18)))
      else $error("vertical energy out of range");

   // the first horizontal share never reaches the whole energy
   a_share_below: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_APPLY && act_h_ff) |-> (q_h < e_h_ff))
      else $error("horizontal share not below energy");

   // a new result only comes out of the final step
   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == S_FIN))
      else $error("result raised outside final step");
endmodule

// ===== rtl/core/grid_heat_exchange_stencil_top.sv =====
// grid_heat_exchange_stencil_top: top level with register port, front, queue and back
// depends on gheat_pkg, gheat_req_if, gheat_rsp_if, gheat_front, gheat_fifo, gheat_back
//
// Usage
//   Cells enter on req_chan in raster order, column 0 row 0 first. Each
//   transaction updates the heat exchange of the cell and its upper and left
//   neighbors; the finished interior cell one row up is emitted on rsp_chan
//   with its column, row and a frame_last marker. Border cells never appear.
//   grid_width (address 0) and grid_height (address 4) are written through
//   the csr_ port while no transaction is in flight; both reset to 1024.
//   The back end sequencer works on one cell at a time; its two five-step
//   restoring dividers, one per pair, split each pair's energy.
//   A result is loaded into the output register in the finish step, after the
//   setup, load, divide, apply and sum steps of the transaction that completes it.
//   A two-entry queue lets the front accept cells while the back works; when
//   the receiver stalls, the back holds its finished result and waits, and
//   the queue then fills and drops req_chan.ready.
//   Reset is synchronous: counters, queue, sequencer and output valid clear;
//   the line store holds no valid state and needs no clearing pass.
module grid_heat_exchange_stencil_top #(
   parameter int MAX_WIDTH  = 1024,
   parameter int MAX_HEIGHT = 1024
) (
   input  logic                              clock,
   input  logic                              reset,
   gheat_req_if.sink                         req_chan,
   gheat_rsp_if.source                       rsp_chan,
   input  logic                              csr_psel,
   input  logic                              csr_penable,
   input  logic                              csr_pwrite,
   input  logic [gheat_pkg::CSR_AW-1:0]      csr_paddr,
   input  logic [gheat_pkg::CSR_DW-1:0]      csr_pwdata,
   output logic [gheat_pkg::CSR_DW-1:0]      csr_prdata,
   output logic                              csr_pready
);
   localparam int CW  = gheat_pkg::CFG_W;
   localparam int WSW = ($clog2(MAX_WIDTH + 1) > CW) ? $clog2(MAX_WIDTH + 1) : CW;
   localparam int HSW = ($clog2(MAX_HEIGHT + 1) > CW) ? $clog2(MAX_HEIGHT + 1) : CW;
   localparam int XW  = $clog2(MAX_WIDTH);
   localparam int QW  = $bits(gheat_pkg::cell_type) + $bits(gheat_pkg::flags_type)
                        + XW + 2 * gheat_pkg::POS_W;

   logic [CW-1:0]  width_ff, height_ff;
   logic [WSW-1:0] width_raw, width_eff;
   logic [HSW-1:0] height_raw, height_eff;
   logic           csr_write;

   logic                        push, pop, fifo_full, fifo_empty;
   gheat_pkg::cell_type         push_cell, head_cell;
   gheat_pkg::flags_type        push_flags, head_flags;
   logic [XW-1:0]               push_x, head_x;
   logic [gheat_pkg::POS_W-1:0] push_col, push_row, head_col, head_row;
   logic [QW-1:0]               q_din, q_dout;

   // register port
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= CW'(1024);
         height_ff <= CW'(1024);
      end else if (csr_write) begin
         unique case (csr_paddr[2])
            gheat_pkg::REG_GRID_WIDTH:  width_ff  <= csr_pwdata[CW-1:0];
            gheat_pkg::REG_GRID_HEIGHT: height_ff <= csr_pwdata[CW-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (csr_paddr[2])
         gheat_pkg::REG_GRID_WIDTH:  csr_prdata = gheat_pkg::CSR_DW'(width_ff);
         gheat_pkg::REG_GRID_HEIGHT: csr_prdata = gheat_pkg::CSR_DW'(height_ff);
         default:                    csr_prdata = '0;
      endcase
   end

   // sizes held to the supported range
   always_comb begin
      width_raw  = WSW'(width_ff);
      height_raw = HSW'(height_ff);
      if (width_raw < WSW'(gheat_pkg::SIZE_MIN)) begin
         width_eff = WSW'(gheat_pkg::SIZE_MIN);
      end else if (width_raw > WSW'(MAX_WIDTH)) begin
         width_eff = WSW'(MAX_WIDTH);
      end else begin
         width_eff = width_raw;
      end
      if (height_raw < HSW'(gheat_pkg::SIZE_MIN)) begin
         height_eff = HSW'(gheat_pkg::SIZE_MIN);
      end else if (height_raw > HSW'(MAX_HEIGHT)) begin
         height_eff = HSW'(MAX_HEIGHT);
      end else begin
         height_eff = height_raw;
      end
   end

   gheat_front #(
      .MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT), .WSW(WSW), .HSW(HSW)
   ) u_front (
      .clock(clock), .reset(reset), .req_chan(req_chan),
      .width_eff(width_eff), .height_eff(height_eff), .fifo_full(fifo_full),
      .push(push), .push_cell(push_cell), .push_flags(push_flags),
      .push_x(push_x), .push_col(push_col), .push_row(push_row)
   );

   // queue payload
   assign q_din = {push_x, push_col, push_row, push_flags, push_cell};
   assign {head_x, head_col, head_row, head_flags, head_cell} = q_dout;

   gheat_fifo #(.DW(QW)) u_fifo (
      .clock(clock), .reset(reset), .push(push), .din(q_din), .full(fifo_full),
      .pop(pop), .dout(q_dout), .empty(fifo_empty)
   );

   gheat_back #(.MAX_WIDTH(MAX_WIDTH)) u_back (
      .clock(clock), .reset(reset), .empty(fifo_empty),
      .head_cell(head_cell), .head_flags(head_flags), .head_x(head_x),
      .head_col(head_col), .head_row(head_row), .pop(pop), .rsp_chan(rsp_chan)
   );
endmodule
